>>> hdl/kufef_pkg.sv
// kufef_pkg: shared widths, types and constants for the Kruskal union-find edge filter.
// No dependencies; compiled first.
package kufef_pkg;

   localparam int NODES    = 1024;
   localparam int NODE_W   = $clog2(NODES);
   localparam int WEIGHT_W = 48;
   localparam int TOTAL_W  = 58;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_EDGE  = 1'b1;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   localparam total_type TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam node_type  NODE_LAST = node_type'(NODES - 1);

   typedef struct packed {
      logic     we;
      node_type waddr;
      node_type wdata;
      node_type raddr;
   } mem_req_type;

   typedef struct packed {
      logic      accepted;
      logic      to_source;
      total_type total_cost;
   } rsp_data_type;

   typedef struct packed {
      logic sweeping;
      logic busy;
   } ctrl_stat_type;

endpackage

>>> hdl/kufef_if.sv
// Valid/ready channel interfaces for edge requests and filter responses.
// Depends on kufef_pkg.
interface kufef_req_if
   import kufef_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       op;
   node_type   node_a;
   node_type   node_b;
   weight_type weight;

   modport source (output valid, output op, output node_a, output node_b, output weight,
                   input ready);
   modport sink   (input valid, input op, input node_a, input node_b, input weight,
                   output ready);
endinterface

interface kufef_rsp_if
   import kufef_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      accepted;
   logic      to_source;
   total_type total_cost;

   modport source (output valid, output accepted, output to_source, output total_cost,
                   input ready);
   modport sink   (input valid, input accepted, input to_source, input total_cost,
                   output ready);
endinterface

>>> hdl/kufef_parent_mem.sv
// Parent pointer memory: one write port, one read port, registered read data.
// Same-cycle write to the read address is forwarded. Depends on kufef_pkg.
module kufef_parent_mem
   import kufef_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output node_type    rdata
);

   node_type mem [NODES];
   node_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we && (mem_req.waddr == mem_req.raddr)) begin
         rdata_ff <= mem_req.wdata;
      end else begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/kufef_ctrl.sv
// Sequencer: clearing sweep, root walks with path halving, link and total update.
// Depends on kufef_pkg and kufef_if; drives kufef_parent_mem.
module kufef_ctrl
   import kufef_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   kufef_req_if.sink     req_bus,
   input  node_type      mem_rdata,
   output mem_req_type   mem_req,
   input  logic          res_free,
   output logic          res_load,
   output rsp_data_type  res_data,
   output ctrl_stat_type stat
);

   localparam logic [2:0] ST_SWEEP  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHK    = 3'd2;
   localparam logic [2:0] ST_HALF   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]   state_ff, state_in;
   node_type     sweep_ff, sweep_in;
   node_type     x_ff, x_in;
   node_type     a_ff, a_in;
   node_type     b_ff, b_in;
   node_type     ra_ff, ra_in;
   logic         phase_ff, phase_in;
   logic         clear_ff, clear_in;
   weight_type   weight_ff, weight_in;
   total_type    total_ff, total_in;
   rsp_data_type res_ff, res_in;

   logic [TOTAL_W:0] sum;
   logic             join_trees;
   total_type        total_new;

   assign sum        = {1'b0, total_ff} + {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, weight_ff};
   assign total_new  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   assign join_trees = (ra_ff != x_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      x_in      = x_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      ra_in     = ra_ff;
      phase_in  = phase_ff;
      clear_in  = clear_ff;
      weight_in = weight_ff;
      total_in  = total_ff;
      res_in    = res_ff;
      mem_req   = '{we: 1'b0, waddr: x_ff, wdata: mem_rdata, raddr: x_ff};
      res_load  = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = sweep_ff;
            mem_req.wdata = sweep_ff;
            sweep_in      = sweep_ff + node_type'(1);
            if (sweep_ff == NODE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_req.raddr = req_bus.node_a;
            if (req_bus.valid) begin
               if (req_bus.op == OP_CLEAR) begin
                  clear_in = 1'b1;
                  total_in = '0;
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  clear_in  = 1'b0;
                  a_in      = req_bus.node_a;
                  b_in      = req_bus.node_b;
                  x_in      = req_bus.node_a;
                  weight_in = req_bus.weight;
                  phase_in  = 1'b0;
                  state_in  = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            // mem_rdata is parent of x
            if (mem_rdata == x_ff) begin
               if (!phase_ff) begin
                  ra_in         = x_ff;
                  x_in          = b_ff;
                  mem_req.raddr = b_ff;
                  phase_in      = 1'b1;
               end else begin
                  state_in = ST_DECIDE;
               end
            end else begin
               mem_req.raddr = mem_rdata;
               state_in      = ST_HALF;
            end
         end
         ST_HALF: begin
            // mem_rdata is grandparent of x: halve and step
            mem_req.we    = 1'b1;
            mem_req.waddr = x_ff;
            mem_req.wdata = mem_rdata;
            mem_req.raddr = mem_rdata;
            x_in          = mem_rdata;
            state_in      = ST_CHK;
         end
         ST_DECIDE: begin
            mem_req.we    = join_trees;
            mem_req.waddr = ra_ff;
            mem_req.wdata = x_ff;
            if (join_trees) begin
               total_in = total_new;
            end
            res_in.accepted   = join_trees;
            res_in.to_source  = join_trees && (a_ff == '0);
            res_in.total_cost = join_trees ? total_new : total_ff;
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_free) begin
               res_load = 1'b1;
               sweep_in = '0;
               state_in = clear_ff ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
         total_ff <= '0;
         clear_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         total_ff <= total_in;
         clear_ff <= clear_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      ra_ff     <= ra_in;
      weight_ff <= weight_in;
      res_ff    <= res_in;
   end

   assign res_data      = res_ff;
   assign stat.sweeping = (state_ff == ST_SWEEP);
   assign stat.busy     = (state_ff != ST_IDLE);

endmodule

>>> hdl/kruskal_union_find_edge_filter.sv
// Top level of the Kruskal edge filter: sequencer, parent memory, response register.
// Depends on kufef_pkg, kufef_if, kufef_parent_mem, kufef_ctrl.
//
//   channel  dir  beat fields
//   req_bus  in   op, node_a, node_b, weight
//   rsp_bus  out  accepted, to_source, total_cost
//
// An edge runs two root walks, one from each endpoint, with a halving step at every
// non-root node; each step is a dependent read pair on the single parent memory.
// A clear beat loads its response, then runs a sweep of all 1024 parent entries.
// After reset the same sweep runs with req_bus.ready low.
// The response register lets the next request start while a response is stalled.
module kruskal_union_find_edge_filter
   import kufef_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kufef_req_if.sink  req_bus,
   kufef_rsp_if.source rsp_bus
);

   mem_req_type   mem_req;
   node_type      mem_rdata;
   logic          res_free;
   logic          res_load;
   rsp_data_type  res_data;
   ctrl_stat_type stat;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   kufef_parent_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   kufef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .mem_rdata (mem_rdata),
      .mem_req   (mem_req),
      .res_free  (res_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .stat      (stat)
   );

   assign res_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.accepted   = rsp_data_ff.accepted;
   assign rsp_bus.to_source  = rsp_data_ff.to_source;
   assign rsp_bus.total_cost = rsp_data_ff.total_cost;

`ifndef SYNTHESIS
   a_reset_sweeps: assert property (@(posedge clock) reset |=> !req_bus.ready && stat.sweeping)
      else $error("request taken before parent sweep");

   a_sweep_identity: assert property (@(posedge clock) disable iff (reset)
      stat.sweeping |-> mem_req.we && (mem_req.wdata == mem_req.waddr))
      else $error("sweep writes a non-identity parent");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> stat.busy && !req_bus.ready)
      else $error("second request taken while busy");

   a_source_implies_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.to_source |-> rsp_bus.accepted)
      else $error("source flag on rejected edge");
`endif

endmodule

>>> test/kufef_checker.sv
`timescale 1ns / 1ps
// kufef_checker: watches the request and response channels of the edge filter,
// keeps a shadow union-find forest and compares every response beat in order.
// Depends on kufef_pkg and kufef_if.
module kufef_checker
   import kufef_pkg::*;
(
   input  logic clock,
   input  logic reset,
   kufef_req_if req_bus,
   kufef_rsp_if rsp_bus,
   output int   mismatches,
   output int   pending,
   output int   results_seen,
   output int   joins_seen
);

   node_type     parent_shadow [NODES];
   total_type    total_shadow;
   rsp_data_type expected_outcome [$];

   function automatic node_type node_of(node_type raw);
      return node_type'(int'(raw) % NODES);
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < NODES; i++) parent_shadow[i] = node_type'(i);
      total_shadow = '0;
   endfunction

   // root search, pointing each visited node at its grandparent
   function automatic node_type walk_to_root(node_type start);
      node_type x, p;
      int       steps;
      x     = start;
      steps = 0;
      p     = node_of(parent_shadow[x]);
      while (p != x && steps < NODES) begin
         parent_shadow[x] = node_of(parent_shadow[p]);
         x                = parent_shadow[x];
         p                = node_of(parent_shadow[x]);
         steps++;
      end
      return x;
   endfunction

   function automatic rsp_data_type predict_edge_outcome(logic op, node_type a_raw,
                                                          node_type b_raw, weight_type w);
      rsp_data_type     r;
      node_type         a, b, ra, rb;
      logic [TOTAL_W:0] sum;
      r = '0;
      if (op == OP_CLEAR) begin
         clear_shadow();
      end else begin
         a  = node_of(a_raw);
         b  = node_of(b_raw);
         ra = walk_to_root(a);
         rb = walk_to_root(b);
         if (ra != rb) begin
            parent_shadow[ra] = rb;
            sum               = {1'b0, total_shadow} + {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, w};
            total_shadow      = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            r.accepted        = 1'b1;
            r.to_source       = (a == '0);
         end
         r.total_cost = total_shadow;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t rsp beat %0d: %s", $time, results_seen, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_data_type got, want;
      if (reset) begin
         clear_shadow();
         expected_outcome.delete();
         pending <= 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.accepted   = rsp_bus.accepted;
            got.to_source  = rsp_bus.to_source;
            got.total_cost = rsp_bus.total_cost;
            if (expected_outcome.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want = expected_outcome.pop_front();
               if (got.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted %b, expected %b",
                                            got.accepted, want.accepted));
               if (got.to_source !== want.to_source)
                  report_mismatch($sformatf("to_source %b, expected %b",
                                            got.to_source, want.to_source));
               if (got.total_cost !== want.total_cost)
                  report_mismatch($sformatf("total_cost %0h, expected %0h",
                                            got.total_cost, want.total_cost));
               if (want.accepted) joins_seen++;
            end
            results_seen++;
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            expected_outcome.insert(expected_outcome.size(),
                                    predict_edge_outcome(req_bus.op, req_bus.node_a,
                                                         req_bus.node_b, req_bus.weight));
         pending <= expected_outcome.size();
      end
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, directed and randomized request beats and response
// back-pressure for the Kruskal edge filter; the verdict uses kufef_checker's count.
// Depends on kufef_pkg, kufef_if, kruskal_union_find_edge_filter and kufef_checker.
module tb_top;
   import kufef_pkg::*;

   localparam int         BEAT_TARGET = 1920;
   localparam int         PHASE_LEN   = 640;
   localparam int         CYCLE_LIMIT = 20_000_000;
   localparam weight_type WEIGHT_MAX  = {WEIGHT_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct  = 35;
   int   recv_stall_pct = 87;
   int   beats_sent     = 0;
   int   clears_sent    = 0;
   int   cycle_count    = 0;
   int   mismatches, pending, results_seen, joins_seen;

   kufef_req_if req_bus ();
   kufef_rsp_if rsp_bus ();

   kruskal_union_find_edge_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   kufef_checker outcome_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mismatches  (mismatches),
      .pending     (pending),
      .results_seen(results_seen),
      .joins_seen  (joins_seen)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, pending);
         $display("kruskal_union_find_edge_filter: mismatch");
         $finish;
      end
   end

   function automatic weight_type bump_weight(weight_type w, weight_type inc);
      return (w > WEIGHT_MAX - inc) ? WEIGHT_MAX : w + inc;
   endfunction

   task automatic push_beat(input logic op, input node_type a, input node_type b,
                            input weight_type w);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.node_a <= a;
      req_bus.node_b <= b;
      req_bus.weight <= w;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      beats_sent++;
      if (op == OP_CLEAR) clears_sent++;
      if (beats_sent == PHASE_LEN) begin
         send_idle_pct  = 87;
         recv_stall_pct = 35;
      end else if (beats_sent == 2 * PHASE_LEN) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   endtask

   initial begin
      int         i, k, kind, span, base, n_edges;
      logic       reverse, with_src, op;
      node_type   a, b;
      weight_type w_run;

      req_bus.valid  = 1'b0;
      req_bus.op     = OP_EDGE;
      req_bus.node_a = '0;
      req_bus.node_b = '0;
      req_bus.weight = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: source edges, same-tree rejects, self loops, extremes, clears
      push_beat(OP_EDGE, 10'd0, 10'd1, 48'd0);
      push_beat(OP_EDGE, 10'd1, 10'd0, 48'd0);
      push_beat(OP_EDGE, 10'd5, 10'd5, 48'd7);
      push_beat(OP_EDGE, 10'd1023, 10'd1022, WEIGHT_MAX);
      push_beat(OP_EDGE, 10'd1022, 10'd1023, WEIGHT_MAX);
      push_beat(OP_EDGE, 10'd0, 10'd1023, WEIGHT_MAX);
      push_beat(OP_EDGE, 10'd1023, 10'd1023, WEIGHT_MAX);
      push_beat(OP_CLEAR, 10'd1023, 10'd1023, WEIGHT_MAX);
      push_beat(OP_EDGE, 10'd0, 10'd0, 48'd0);
      push_beat(OP_EDGE, 10'd1023, 10'd0, 48'd1);
      push_beat(OP_EDGE, 10'd341, 10'd682, 48'h5555_5555_5555);
      push_beat(OP_EDGE, 10'd682, 10'd341, 48'haaaa_aaaa_aaaa);
      push_beat(OP_EDGE, 10'd512, 10'd511, 48'h8000_0000_0000);
      for (i = 2; i < 10; i++) push_beat(OP_EDGE, node_type'(i), node_type'(i + 1), 48'd9);
      push_beat(OP_EDGE, 10'd2, 10'd10, 48'd9);
      push_beat(OP_EDGE, 10'd10, 10'd2, 48'd9);
      push_beat(OP_CLEAR, 10'd0, 10'd0, 48'd0);
      push_beat(OP_CLEAR, 10'd0, 10'd0, 48'd0);
      push_beat(OP_EDGE, 10'd1023, 10'd0, 48'd3);

      while (beats_sent < BEAT_TARGET) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            // random forest over a node window, mostly sorted weights; sometimes no clear
            if ($urandom_range(9) != 0)
               push_beat(OP_CLEAR, node_type'($urandom), node_type'($urandom),
                         weight_type'({$urandom, $urandom}));
            span     = ($urandom_range(9) == 0) ? $urandom_range(200, NODES)
                                                : $urandom_range(2, 40);
            base     = $urandom_range(NODES - span);
            n_edges  = $urandom_range(span / 2 + 1, 2 * span);
            if (n_edges > 120) n_edges = 120;
            with_src = 1'($urandom_range(1));
            w_run    = ($urandom_range(3) == 0) ? weight_type'({$urandom, $urandom})
                                                : weight_type'($urandom_range(1000));
            for (k = 0; k < n_edges; k++) begin
               a = node_type'(base + $urandom_range(span - 1));
               b = node_type'(base + $urandom_range(span - 1));
               if (with_src && $urandom_range(4) == 0) a = '0;
               if (with_src && $urandom_range(9) == 0) b = '0;
               if ($urandom_range(29) == 0) w_run = w_run >> $urandom_range(1, 8);
               else w_run = bump_weight(w_run, ($urandom_range(3) == 0) ? weight_type'(0)
                                               : weight_type'($urandom_range(5000)));
               push_beat(OP_EDGE, a, b, w_run);
            end
         end else if (kind < 88) begin
            // linked chain, then queries that walk it
            push_beat(OP_CLEAR, node_type'($urandom), node_type'($urandom), '0);
            span    = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(4, 48);
            base    = $urandom_range(NODES - span);
            reverse = 1'($urandom_range(1));
            w_run   = weight_type'($urandom_range(100));
            for (k = 0; k < span - 1; k++) begin
               a     = node_type'(base + k);
               b     = node_type'(base + k + 1);
               w_run = bump_weight(w_run, weight_type'($urandom_range(3)));
               if (reverse) push_beat(OP_EDGE, b, a, w_run);
               else push_beat(OP_EDGE, a, b, w_run);
            end
            for (k = 0; k < span / 2 + 2; k++) begin
               a     = node_type'(base + $urandom_range(span - 1));
               b     = ($urandom_range(3) == 0) ? node_type'($urandom)
                                                : node_type'(base + $urandom_range(span - 1));
               w_run = bump_weight(w_run, weight_type'($urandom_range(50)));
               push_beat(OP_EDGE, a, b, w_run);
            end
         end else begin
            // noise: unsorted weights, any nodes, stray clears
            n_edges = $urandom_range(20, 60);
            for (k = 0; k < n_edges; k++) begin
               op = ($urandom_range(19) == 0) ? OP_CLEAR : OP_EDGE;
               push_beat(op, node_type'($urandom), node_type'($urandom),
                         weight_type'({$urandom, $urandom}));
            end
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("covered %0d request beats (%0d clears) and %0d response beats, %0d joins",
               beats_sent, clears_sent, results_seen, joins_seen);
      $display("back-pressure: sender gaps then receiver stalls swapped, then none");
      if (mismatches == 0) begin
         $display("kruskal_union_find_edge_filter: match");
      end else begin
         $display("kruskal_union_find_edge_filter: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/kufef_pkg.sv
hdl/kufef_if.sv
hdl/kufef_parent_mem.sv
hdl/kufef_ctrl.sv
hdl/kruskal_union_find_edge_filter.sv
test/kufef_checker.sv
test/tb_top.sv
